// ===== rtl/core/fgrm_pkg.sv =====
// Shared constants, types and saturation helpers of the frame gap rate monitor.
`default_nettype none

package fgrm_pkg;

  // Field widths
  localparam int CounterBits = 24;
  localparam int FracBits    = 8;
  localparam int FpsBits     = 24;
  localparam int NomBits     = 10;

  // Internal arithmetic widths
  localparam int MissW = CounterBits + 2;   // missed count
  localparam int DiffW = CounterBits + 3;   // differences of readings
  localparam int SumW  = CounterBits + 4;   // missed count update before saturation
  localparam int TotW  = CounterBits + 1;   // span of the window
  localparam int ProdW = NomBits + 1 + DiffW;
  localparam int NumW  = ProdW + FracBits;  // dividend magnitude
  localparam int DenW  = CounterBits;       // divisor magnitude
  localparam int QW    = FpsBits;           // quotient bits kept by the divider
  localparam int CmpW  = (NumW > DenW + QW) ? NumW : DenW + QW;
  localparam int CntW  = $clog2(QW + 1);

  localparam logic [NomBits-1:0] NomReset = NomBits'(30);

  localparam logic signed [MissW-1:0] MissMax = {1'b0, {(MissW-1){1'b1}}};
  localparam logic signed [MissW-1:0] MissMin = {1'b1, {(MissW-1){1'b0}}};
  localparam logic signed [TotW-1:0]  OutMax  = {1'b0, {(TotW-1){1'b1}}};
  localparam logic signed [TotW-1:0]  OutMin  = {1'b1, {(TotW-1){1'b0}}};
  localparam logic signed [FpsBits-1:0] FpsMax = {1'b0, {(FpsBits-1){1'b1}}};
  localparam logic signed [FpsBits-1:0] FpsMin = {1'b1, {(FpsBits-1){1'b0}}};

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } fgrm_div_stat_t;

  // Sequencer states
  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_CMP  = 9'b000000010,
    ST_BACK = 9'b000000100,
    ST_GAP  = 9'b000001000,
    ST_TOT  = 9'b000010000,
    ST_PROD = 9'b000100000,
    ST_PREP = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } fgrm_state_e;

  // Clamp an updated missed count to its register range
  function automatic logic signed [MissW-1:0] sat_miss(input logic signed [SumW-1:0] x);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(MissMax);
    lo = SumW'(MissMin);
    if (x > hi) begin
      return MissMax;
    end else if (x < lo) begin
      return MissMin;
    end
    return MissW'(x);
  endfunction

  // Clamp the missed count to the output field range
  function automatic logic signed [TotW-1:0] sat_out(input logic signed [MissW-1:0] x);
    logic signed [MissW-1:0] hi;
    logic signed [MissW-1:0] lo;
    hi = MissW'(OutMax);
    lo = MissW'(OutMin);
    if (x > hi) begin
      return OutMax;
    end else if (x < lo) begin
      return OutMin;
    end
    return TotW'(x);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fgrm_in_if.sv =====
// Input channel: one frame counter reading per word.
`default_nettype none

interface fgrm_in_if import fgrm_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CounterBits-1:0] frame_number;
  logic                   last;

  modport source (output valid, output frame_number, output last, input ready);
  modport sink   (input valid, input frame_number, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fgrm_out_if.sv =====
// Output channel: one window summary per word.
`default_nettype none

interface fgrm_out_if import fgrm_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [TotW-1:0]     missed_cnt;
  logic signed [TotW-1:0]     frame_span;
  logic signed [FpsBits-1:0]  measured_fps;
  logic                       zero_span;

  modport source (output valid, output missed_cnt, output frame_span,
                  output measured_fps, output zero_span, input ready);
  modport sink   (input valid, input missed_cnt, input frame_span,
                  input measured_fps, input zero_span, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fgrm_div.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle, with overflow detect.
`default_nettype none

module fgrm_div import fgrm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NumW-1:0]   num_i,
  input  wire logic [DenW-1:0]   den_i,
  output logic      [QW-1:0]     quot_o,
  output fgrm_div_stat_t         stat_o
);

  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q, rem_d;
  logic [QW-1:0]   low_q;
  logic [QW-1:0]   quot_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q, ovf_q;

  logic [DenW:0]   trial;
  logic            take;
  logic            ovf_start;

  // Quotient does not fit when the dividend reaches the divisor shifted by QW
  assign ovf_start = CmpW'(num_i) >= (CmpW'(den_i) << QW);

  // Shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem_q, low_q[QW-1]};
    take  = trial >= {1'b0, den_q};
    rem_d = take ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        ovf_q <= ovf_start;
        if (ovf_start) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CntW'(QW);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q  <= den_i;
      rem_q  <= DenW'(num_i >> QW);
      low_q  <= num_i[QW-1:0];
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      low_q  <= low_q << 1;
      quot_q <= {quot_q[QW-2:0], take};
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/core/frame_gap_rate_monitor_top.sv =====
// Frame gap rate monitor: a reading passes the compare, withdraw and gap states, back to idle.
// A last reading adds span, product, divider load and emit states around the divider run
// (24 quotient bits, then done); a zero span skips the divider, an overflow ends it early.
// The input is not ready while a reading is worked on; the result sits in an output
// register while the next reading is taken, and emit waits while that register is full.
// Reset (async, active low) clears the history and sets nominal_fps to 30.
`default_nettype none

module frame_gap_rate_monitor_top import fgrm_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  fgrm_in_if.sink                 in_i,
  fgrm_out_if.source              out_o,
  input  wire logic               cfg_we_i,
  input  wire logic [NomBits-1:0] cfg_wdata_i
);

  fgrm_state_e state_q, state_d;

  logic [NomBits-1:0]       nom_q;
  logic                     started_q;
  logic [CounterBits-1:0]   v_q;
  logic                     last_q;
  logic [CounterBits-1:0]   first_q;
  logic signed [MissW-1:0]  prev_q, older_q, missed_q;
  logic                     glitch_q;
  logic signed [TotW-1:0]   total_q;
  logic                     zero_q;
  logic signed [ProdW-1:0]  prod_q;
  logic                     neg_q;

  logic                     out_valid_q;
  logic signed [TotW-1:0]   out_missed_q, out_total_q;
  logic signed [FpsBits-1:0] out_fps_q;
  logic                     out_zero_q;

  logic                     in_acc;
  logic                     out_free;

  logic signed [DiffW-1:0]  vx, da, db, back, gap, diff;
  logic [DiffW-1:0]         abs_a, abs_b;
  logic signed [ProdW-1:0]  prod_d;
  logic [ProdW-1:0]         prod_mag;
  logic [NumW-1:0]          div_num;
  logic [DenW-1:0]          div_den;
  logic                     div_start;
  logic [QW-1:0]            quot;
  fgrm_div_stat_t           div_stat;
  logic signed [FpsBits-1:0] rate;

  assign in_acc     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_o.ready;
  assign div_start  = (state_q == ST_PREP);

  // Differences against the history
  always_comb begin
    vx    = signed'(DiffW'({1'b0, v_q}));
    da    = vx - DiffW'(older_q);
    db    = vx - DiffW'(prev_q);
    abs_a = da[DiffW-1] ? DiffW'(-da) : DiffW'(da);
    abs_b = db[DiffW-1] ? DiffW'(-db) : DiffW'(db);
    back  = DiffW'(prev_q) - DiffW'(older_q);
    gap   = vx - DiffW'(prev_q);
    diff  = DiffW'(total_q) - DiffW'(missed_q);
  end

  // Rate product and divider operands
  always_comb begin
    prod_d   = signed'(ProdW'({1'b0, nom_q})) * ProdW'(diff);
    prod_mag = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
    div_num  = NumW'(prod_mag) << FracBits;
    div_den  = total_q[TotW-1] ? DenW'(-total_q) : DenW'(total_q);
  end

  fgrm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .quot_o (quot),
    .stat_o (div_stat)
  );

  // Apply sign and saturate the quotient
  always_comb begin
    if (neg_q) begin
      if (div_stat.ovf || (quot > QW'(1) << (FpsBits - 1))) begin
        rate = FpsMin;
      end else begin
        rate = FpsBits'(-signed'({1'b0, quot}));
      end
    end else begin
      if (div_stat.ovf || (quot >= QW'(1) << (FpsBits - 1))) begin
        rate = FpsMax;
      end else begin
        rate = FpsBits'(quot);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_CMP;
      ST_CMP:  state_d = ST_BACK;
      ST_BACK: state_d = ST_GAP;
      ST_GAP:  state_d = last_q ? ST_TOT : ST_IDLE;
      ST_TOT:  state_d = ST_PROD;
      ST_PROD: state_d = zero_q ? ST_FIN : ST_PREP;
      ST_PREP: state_d = ST_DIV;
      ST_DIV:  if (div_stat.done) state_d = ST_FIN;
      ST_FIN:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state, history and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nom_q       <= NomReset;
      started_q   <= 1'b0;
      first_q     <= '0;
      prev_q      <= '0;
      older_q     <= '0;
      missed_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        nom_q <= cfg_wdata_i;
      end
      // Raise valid on emit, drop it once the word is taken
      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          // Seed the history from the first reading
          if (in_acc && !started_q) begin
            started_q <= 1'b1;
            first_q   <= in_i.frame_number;
            prev_q    <= MissW'({2'b00, in_i.frame_number}) - MissW'(1);
            older_q   <= MissW'({2'b00, in_i.frame_number}) - MissW'(2);
          end
        end
        ST_BACK: begin
          // Withdraw the gap of a glitched reading and drop it
          if (glitch_q) begin
            if (back > DiffW'(1)) begin
              missed_q <= sat_miss(SumW'(missed_q) - SumW'(back));
            end
            prev_q <= older_q;
          end
        end
        ST_GAP: begin
          // Count a forward jump and advance the history
          if (gap > DiffW'(1)) begin
            missed_q <= sat_miss(SumW'(missed_q) + SumW'(gap));
          end
          older_q <= prev_q;
          prev_q  <= MissW'({2'b00, v_q});
        end
        ST_FIN: begin
          // Emit the summary and clear the window
          if (out_free) begin
            started_q   <= 1'b0;
            first_q     <= '0;
            prev_q      <= '0;
            older_q     <= '0;
            missed_q    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      v_q    <= in_i.frame_number;
      last_q <= in_i.last;
    end
    if (state_q == ST_CMP) begin
      glitch_q <= abs_a < abs_b;
    end
    if (state_q == ST_TOT) begin
      total_q <= TotW'({1'b0, v_q}) - TotW'({1'b0, first_q});
      zero_q  <= (v_q == first_q);
    end
    if (state_q == ST_PROD) begin
      prod_q <= prod_d;
      neg_q  <= prod_d[ProdW-1] ^ total_q[TotW-1];
    end
    if ((state_q == ST_FIN) && out_free) begin
      out_missed_q <= sat_out(missed_q);
      out_total_q  <= total_q;
      out_fps_q    <= zero_q ? '0 : rate;
      out_zero_q   <= zero_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.missed_cnt    = out_missed_q;
  assign out_o.frame_span    = out_total_q;
  assign out_o.measured_fps  = out_fps_q;
  assign out_o.zero_span     = out_zero_q;

  // A new word appears only after the final state
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FIN))
    else $error("output word without a finished window");

  // A zero span always reports a zero rate
  a_zero_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.zero_span) |-> (out_o.measured_fps == '0))
    else $error("nonzero rate on zero span");

  // Every accepted reading leaves the window started
  a_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> started_q)
    else $error("history not seeded");

  // The divider never runs on a zero span
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> !zero_q)
    else $error("divider started on zero span");

endmodule

`default_nettype wire
